>>> hdl/multichannel_biquad_iir_filter_defines.svh
// assertion helpers for the top-level rtl
`ifndef MULTICHANNEL_BIQUAD_IIR_FILTER_DEFINES_SVH
`define MULTICHANNEL_BIQUAD_IIR_FILTER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define BIQ_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("biquad assertion failed");

// next-cycle implication, checked out of reset
`define BIQ_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("biquad assertion failed");

`endif

>>> hdl/biq_pkg.sv
`default_nettype none
package biq_pkg;

    localparam int CHANNELS      = 8;
    localparam int SAMPLE_BITS   = 24;
    localparam int CHAN_BITS     = 3;
    localparam int COEF_BITS     = 18;
    localparam int FRAC_BITS     = 14;
    localparam int CFG_IDX_BITS  = 3;
    localparam int HIST_IDX_BITS = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // register indexes on the configuration channel
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_B0 = 3'd0,
        REG_B1 = 3'd1,
        REG_B2 = 3'd2,
        REG_A1 = 3'd3,
        REG_A2 = 3'd4
    } cfg_reg_t;

    localparam logic signed [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(1 << FRAC_BITS);

    typedef struct packed {
        logic signed [COEF_BITS-1:0] b0;
        logic signed [COEF_BITS-1:0] b1;
        logic signed [COEF_BITS-1:0] b2;
        logic signed [COEF_BITS-1:0] a1;
        logic signed [COEF_BITS-1:0] a2;
    } coef_set_t;

    // one channel's delay line as read from the history bank
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] x1;
        logic signed [SAMPLE_BITS-1:0] x2;
        logic signed [SAMPLE_BITS-1:0] y1;
        logic signed [SAMPLE_BITS-1:0] y2;
    } hist_t;

endpackage
`default_nettype wire

>>> hdl/biq_coef_regs.sv
`default_nettype none
module biq_coef_regs (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    input  wire logic [biq_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [biq_pkg::COEF_BITS-1:0]     cfg_data,
    output biq_pkg::coef_set_t                     coef
);
    import biq_pkg::*;

    coef_set_t coef_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg.b0 <= COEF_ONE;
            coef_reg.b1 <= '0;
            coef_reg.b2 <= '0;
            coef_reg.a1 <= '0;
            coef_reg.a2 <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_B0:  coef_reg.b0 <= $signed(cfg_data);
                REG_B1:  coef_reg.b1 <= $signed(cfg_data);
                REG_B2:  coef_reg.b2 <= $signed(cfg_data);
                REG_A1:  coef_reg.a1 <= $signed(cfg_data);
                REG_A2:  coef_reg.a2 <= $signed(cfg_data);
                default: ; // unknown index, write dropped
            endcase
        end
    end

    assign coef = coef_reg;

endmodule
`default_nettype wire

>>> hdl/biq_history.sv
`default_nettype none
module biq_history (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic [biq_pkg::HIST_IDX_BITS-1:0]    idx,
    input  wire logic                                 wr_en,
    input  wire logic signed [biq_pkg::SAMPLE_BITS-1:0] wr_x,
    input  wire logic signed [biq_pkg::SAMPLE_BITS-1:0] wr_y,
    output biq_pkg::hist_t                            hist
);
    import biq_pkg::*;

    logic signed [SAMPLE_BITS-1:0] x1_reg [CHANNELS];
    logic signed [SAMPLE_BITS-1:0] x2_reg [CHANNELS];
    logic signed [SAMPLE_BITS-1:0] y1_reg [CHANNELS];
    logic signed [SAMPLE_BITS-1:0] y2_reg [CHANNELS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                x1_reg[i] <= '0;
                x2_reg[i] <= '0;
                y1_reg[i] <= '0;
                y2_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            // shift the channel's delay line by one sample
            x2_reg[idx] <= x1_reg[idx];
            x1_reg[idx] <= wr_x;
            y2_reg[idx] <= y1_reg[idx];
            y1_reg[idx] <= wr_y;
        end
    end

    assign hist.x1 = x1_reg[idx];
    assign hist.x2 = x2_reg[idx];
    assign hist.y1 = y1_reg[idx];
    assign hist.y2 = y2_reg[idx];

endmodule
`default_nettype wire

>>> hdl/biq_mac.sv
`default_nettype none
module biq_mac (
    input  wire logic signed [biq_pkg::SAMPLE_BITS-1:0] x,
    input  wire biq_pkg::hist_t                         hist,
    input  wire biq_pkg::coef_set_t                     coef,
    output logic signed [biq_pkg::SAMPLE_BITS-1:0]      y
);
    import biq_pkg::*;

    localparam int PROD_BITS = COEF_BITS + SAMPLE_BITS;
    localparam int ACC_BITS  = PROD_BITS + 3;
    localparam int RND_BITS  = ACC_BITS - FRAC_BITS;

    localparam logic signed [ACC_BITS-1:0] HALF_LSB = ACC_BITS'(1 << (FRAC_BITS - 1));
    localparam logic signed [RND_BITS-1:0] RND_MAX =
        {{(RND_BITS - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic signed [RND_BITS-1:0] RND_MIN = ~RND_MAX;

    logic signed [PROD_BITS-1:0] p_b0, p_b1, p_b2, p_a1, p_a2;
    logic signed [ACC_BITS-1:0]  acc;
    logic signed [ACC_BITS-1:0]  acc_rnd;
    logic signed [RND_BITS-1:0]  rnd;

    // five products in parallel, then one exact sum
    assign p_b0 = coef.b0 * x;
    assign p_b1 = coef.b1 * hist.x1;
    assign p_b2 = coef.b2 * hist.x2;
    assign p_a1 = coef.a1 * hist.y1;
    assign p_a2 = coef.a2 * hist.y2;

    assign acc = ACC_BITS'(p_b0) + ACC_BITS'(p_b1) + ACC_BITS'(p_b2)
               - ACC_BITS'(p_a1) - ACC_BITS'(p_a2);

    // round half up, then floor shift
    assign acc_rnd = acc + HALF_LSB;
    assign rnd     = $signed(acc_rnd[ACC_BITS-1:FRAC_BITS]);

    always_comb
    begin
        if (rnd > RND_MAX)
            y = RND_MAX[SAMPLE_BITS-1:0];
        else if (rnd < RND_MIN)
            y = RND_MIN[SAMPLE_BITS-1:0];
        else
            y = rnd[SAMPLE_BITS-1:0];
    end

endmodule
`default_nettype wire

>>> hdl/multichannel_biquad_iir_filter.sv
// an accepted item is registered in the input stage, then in the result register, for the master side
// throughput: one item per cycle unless stalled, set by combinational mac and history loop
// back-to-back samples of the same channel see the history written by the sample before
// reset (rst_n, async, active low): all channel histories zero, b0 = 1.0, other coefs zero
// reset is immediate: no clearing pass, input ready right after reset is released
`default_nettype none
module multichannel_biquad_iir_filter (
    input  wire logic                                clk,
    input  wire logic                                rst_n,

    // sample input stream
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [biq_pkg::SAMPLE_BITS-1:0]     s_axis_tdata,  // [23:0] in_sample
    input  wire logic [biq_pkg::CHAN_BITS-1:0]       s_axis_tuser,  // [2:0] chan_index

    // filtered output stream
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic [biq_pkg::SAMPLE_BITS-1:0]          m_axis_tdata,  // [23:0] out_sample
    output logic [biq_pkg::CHAN_BITS-1:0]            m_axis_tuser,  // [2:0] out_chan

    // coefficient write channel
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [biq_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  wire logic [biq_pkg::COEF_BITS-1:0]       cfg_data
);
    import biq_pkg::*;

    // input register stage
    logic                          in_valid_reg;
    logic [CHAN_BITS-1:0]          in_chan_reg;
    logic signed [SAMPLE_BITS-1:0] in_sample_reg;

    // result register stage
    logic                          out_valid_reg;
    logic [CHAN_BITS-1:0]          out_chan_reg;
    logic signed [SAMPLE_BITS-1:0] out_sample_reg;
    logic signed [SAMPLE_BITS-1:0] out_sample_next;

    logic                          advance;
    logic                          chan_ok;
    logic [HIST_IDX_BITS-1:0]      hist_idx;
    coef_set_t                     coef;
    hist_t                         hist;
    logic signed [SAMPLE_BITS-1:0] mac_y;

    // coefficients can be taken every cycle
    assign cfg_ready = 1'b1;

    // item in the input stage moves on when the result register is free or draining
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    // channels beyond the history bank give zero and leave state alone
    assign chan_ok  = (32'(in_chan_reg) < CHANNELS);
    assign hist_idx = HIST_IDX_BITS'(in_chan_reg);

    biq_coef_regs u_coef (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coef      (coef)
    );

    biq_history u_hist (
        .clk   (clk),
        .rst_n (rst_n),
        .idx   (hist_idx),
        .wr_en (advance && chan_ok),
        .wr_x  (in_sample_reg),
        .wr_y  (mac_y),
        .hist  (hist)
    );

    biq_mac u_mac (
        .x    (in_sample_reg),
        .hist (hist),
        .coef (coef),
        .y    (mac_y)
    );

    assign out_sample_next = chan_ok ? mac_y : '0;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_chan_reg   <= s_axis_tuser;
            in_sample_reg <= $signed(s_axis_tdata);
        end
        if (advance)
        begin
            out_chan_reg   <= in_chan_reg;
            out_sample_reg <= out_sample_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_sample_reg;
    assign m_axis_tuser  = out_chan_reg;

`include "multichannel_biquad_iir_filter_defines.svh"

    // both stages full and output stalled: no new transfer may be taken
    `BIQ_ASSERT_IMP(a_full_blocks_input, in_valid_reg && out_valid_reg && !m_axis_tready, !s_axis_tready)

    // an item leaving the input stage always lands in the result register
    `BIQ_ASSERT_NXT(a_advance_loads_result, advance, out_valid_reg)

    // a channel outside the bank yields a zero sample
    `BIQ_ASSERT_NXT(a_bad_chan_zero, advance && !chan_ok, m_axis_tdata == '0)

    // input stage empty means nothing can advance
    `BIQ_ASSERT_IMP(a_no_advance_when_empty, !in_valid_reg, !advance && s_axis_tready)

endmodule
`default_nettype wire

>>> tb/sv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import biq_pkg::*;

    // run shape
    localparam int ITEMS_PER_PHASE   = 154;
    localparam int RANDOM_PHASES     = 12;
    localparam int DRAIN_CYCLES      = 4;
    localparam int CYCLE_LIMIT       = 200000;
    // one long receiver hold-off, started once this many results have come
    localparam int LONG_STALL_AT     = 300;
    localparam int LONG_STALL_CYCLES = 120;

    localparam int NUM_COEF_REGS = 5;
    localparam int NUM_CFG_SLOTS = 1 << CFG_IDX_BITS;

    localparam longint SAMPLE_MAX = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

    localparam logic signed [COEF_BITS-1:0] COEF_MAX  = {1'b0, {(COEF_BITS-1){1'b1}}};
    localparam logic signed [COEF_BITS-1:0] COEF_MIN  = {1'b1, {(COEF_BITS-1){1'b0}}};
    localparam logic signed [COEF_BITS-1:0] COEF_HALF = COEF_BITS'(1 << (FRAC_BITS - 1));
    localparam logic signed [COEF_BITS-1:0] COEF_ZERO = '0;

    localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // how often each side idles
    typedef enum {
        PACE_SEND_LIGHT_RECV_HEAVY,
        PACE_SEND_HEAVY_RECV_LIGHT,
        PACE_FULL_RATE
    } pace_t;

    typedef struct packed {
        logic [CHAN_BITS-1:0]          chan;
        logic signed [SAMPLE_BITS-1:0] sample;
    } chan_sample_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [SAMPLE_BITS-1:0]  s_axis_tdata = '0;   // [23:0] in_sample
    logic [CHAN_BITS-1:0]    s_axis_tuser = '0;   // [2:0] chan_index

    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [SAMPLE_BITS-1:0]  m_axis_tdata;        // [23:0] out_sample
    logic [CHAN_BITS-1:0]    m_axis_tuser;        // [2:0] out_chan

    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [COEF_BITS-1:0]    cfg_data = '0;

    // samples waiting to be sent, filtered samples waiting to come out
    chan_sample_t sample_feed[$];
    chan_sample_t pending_filtered[$];

    pace_t pace = PACE_SEND_LIGHT_RECV_HEAVY;
    int    mismatches = 0;
    int    results_seen = 0;
    int    cycle_count = 0;
    int    stall_left = 0;
    logic  stall_done = 1'b0;

    // filter state as the block should hold it
    logic signed [COEF_BITS-1:0]   coef_mirror [NUM_COEF_REGS];
    logic signed [SAMPLE_BITS-1:0] hist_x1 [CHANNELS];
    logic signed [SAMPLE_BITS-1:0] hist_x2 [CHANNELS];
    logic signed [SAMPLE_BITS-1:0] hist_y1 [CHANNELS];
    logic signed [SAMPLE_BITS-1:0] hist_y2 [CHANNELS];

    multichannel_biquad_iir_filter u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic int send_idle_pct();
        case (pace)
            PACE_SEND_LIGHT_RECV_HEAVY: return 19;
            PACE_SEND_HEAVY_RECV_LIGHT: return 66;
            default:                    return 0;
        endcase
    endfunction

    function automatic int recv_idle_pct();
        case (pace)
            PACE_SEND_LIGHT_RECV_HEAVY: return 66;
            PACE_SEND_HEAVY_RECV_LIGHT: return 19;
            default:                    return 0;
        endcase
    endfunction

    // direct form 1 biquad for one sample: exact sum, round half up, clamp,
    // then shift the channel's delay line
    function automatic chan_sample_t filter_sample(logic [CHAN_BITS-1:0] ch,
                                                   logic signed [SAMPLE_BITS-1:0] x);
        longint       acc;
        longint       y;
        chan_sample_t r;
        r.chan = ch;
        if (int'(ch) >= CHANNELS)
        begin
            r.sample = '0;
            return r;
        end
        acc = longint'(coef_mirror[REG_B0]) * longint'(x)
            + longint'(coef_mirror[REG_B1]) * longint'(hist_x1[ch])
            + longint'(coef_mirror[REG_B2]) * longint'(hist_x2[ch])
            - longint'(coef_mirror[REG_A1]) * longint'(hist_y1[ch])
            - longint'(coef_mirror[REG_A2]) * longint'(hist_y2[ch]);
        y = (acc + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (y > SAMPLE_MAX)
            y = SAMPLE_MAX;
        else if (y < SAMPLE_MIN)
            y = SAMPLE_MIN;
        hist_x2[ch] = hist_x1[ch];
        hist_x1[ch] = x;
        hist_y2[ch] = hist_y1[ch];
        hist_y1[ch] = SAMPLE_BITS'(y);
        r.sample = SAMPLE_BITS'(y);
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    // sample driver: holds an item until the transfer, then loads the next one
    always @(posedge clk or negedge rst_n)
    begin : sample_driver
        chan_sample_t nxt;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                pending_filtered.push_back(filter_sample(s_axis_tuser, s_axis_tdata));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (sample_feed.size() != 0 && $urandom_range(0, 99) >= send_idle_pct())
                begin
                    nxt = sample_feed.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= nxt.sample;
                    s_axis_tuser  <= nxt.chan;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result monitor and receiver pacing, including the one long hold-off
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        chan_sample_t exp_item;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
            stall_done    <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                if (pending_filtered.size() == 0)
                    report_mismatch($sformatf("unexpected result chan %0d sample %0d",
                                              m_axis_tuser, $signed(m_axis_tdata)));
                else
                begin
                    exp_item = pending_filtered.pop_front();
                    if (m_axis_tuser !== exp_item.chan)
                        report_mismatch($sformatf("out_chan %0d, expected %0d",
                                                  m_axis_tuser, exp_item.chan));
                    if (m_axis_tdata !== exp_item.sample)
                        report_mismatch($sformatf("chan %0d out_sample %0d, expected %0d",
                                                  exp_item.chan, $signed(m_axis_tdata),
                                                  exp_item.sample));
                end
            end
            if (stall_left != 0)
            begin
                stall_left    <= stall_left - 1;
                m_axis_tready <= 1'b0;
            end
            else if (!stall_done && results_seen >= LONG_STALL_AT)
            begin
                // sender keeps offering, so the block backs up into its input
                stall_done    <= 1'b1;
                stall_left    <= LONG_STALL_CYCLES;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct());
        end
    end

    // one transfer on the coefficient channel, mirrored into the predictor
    task automatic write_coef(logic [CFG_IDX_BITS-1:0] idx, logic [COEF_BITS-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (int'(idx) < NUM_COEF_REGS)
            coef_mirror[idx] = val;
    endtask

    task automatic load_coefs(logic [COEF_BITS-1:0] b0, logic [COEF_BITS-1:0] b1,
                              logic [COEF_BITS-1:0] b2, logic [COEF_BITS-1:0] a1,
                              logic [COEF_BITS-1:0] a2);
        write_coef(REG_B0, b0);
        write_coef(REG_B1, b1);
        write_coef(REG_B2, b2);
        write_coef(REG_A1, a1);
        write_coef(REG_A2, a2);
    endtask

    task automatic queue_sample(int ch, logic signed [SAMPLE_BITS-1:0] x);
        chan_sample_t it;
        it.chan   = CHAN_BITS'(ch);
        it.sample = x;
        sample_feed.push_back(it);
    endtask

    // block is idle once nothing is queued, offered or outstanding
    task automatic wait_drained();
        @(negedge clk);
        while (sample_feed.size() != 0 || s_axis_tvalid || pending_filtered.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [COEF_BITS-1:0] pick_coef(int kind);
        case (kind)
            0: return COEF_BITS'($urandom);
            1: return COEF_BITS'(int'($urandom_range(0, 32768)) - 16384);
            2:
            begin
                case ($urandom_range(0, 2))
                    0:       return COEF_MAX;
                    1:       return COEF_MIN;
                    default: return COEF_ZERO;
                endcase
            end
            default: return ($urandom_range(0, 2) == 0) ? COEF_BITS'($urandom) : COEF_ZERO;
        endcase
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return SMP_MAX;
            1:       return SMP_MIN;
            2:       return SAMPLE_BITS'(int'($urandom_range(0, 64)) - 32);
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    initial
    begin : stimulus
        int ch;
        int kind;
        for (int i = 0; i < CHANNELS; i++)
        begin
            hist_x1[i] = '0;
            hist_x2[i] = '0;
            hist_y1[i] = '0;
            hist_y2[i] = '0;
        end
        coef_mirror[REG_B0] = COEF_ONE;
        coef_mirror[REG_B1] = '0;
        coef_mirror[REG_B2] = '0;
        coef_mirror[REG_A1] = '0;
        coef_mirror[REG_A2] = '0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset coefficients pass samples straight through: field extremes,
        // alternating bit patterns, same channel back to back
        queue_sample(0, SMP_MAX);
        queue_sample(1, SMP_MIN);
        queue_sample(CHANNELS - 1, '0);
        queue_sample(2, -1);
        queue_sample(3, 1);
        queue_sample(5, 24'hAAAAAA);
        queue_sample(6, 24'h555555);
        queue_sample(0, SMP_MAX);
        queue_sample(0, SMP_MIN);
        wait_drained();

        // extreme coefficients drive the sum into both clamps
        load_coefs(COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX);
        @(negedge clk);
        queue_sample(4, SMP_MAX);
        queue_sample(4, SMP_MAX);
        queue_sample(4, SMP_MIN);
        queue_sample(4, SMP_MIN);
        queue_sample(4, 1);
        wait_drained();

        // gain one half: exact halves round toward plus infinity;
        // writes to unused register slots must leave b0 alone
        load_coefs(COEF_HALF, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO);
        for (int idx = NUM_COEF_REGS; idx < NUM_CFG_SLOTS; idx++)
            write_coef(CFG_IDX_BITS'(idx), COEF_BITS'($urandom));
        @(negedge clk);
        queue_sample(1, 1);
        queue_sample(1, -1);
        queue_sample(1, 3);
        queue_sample(1, -3);
        wait_drained();

        // random phases, each under its own coefficient set
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            kind = ph % 4;
            load_coefs(pick_coef(kind), pick_coef(kind), pick_coef(kind),
                       pick_coef(kind), pick_coef(kind));
            @(negedge clk);
            if (ph < RANDOM_PHASES / 3)
                pace = PACE_SEND_LIGHT_RECV_HEAVY;
            else if (ph < 2 * RANDOM_PHASES / 3)
                pace = PACE_SEND_HEAVY_RECV_LIGHT;
            else
                pace = PACE_FULL_RATE;
            ch = $urandom_range(0, CHANNELS - 1);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // bursts on one channel exercise back-to-back history use
                if ($urandom_range(0, 9) >= 3)
                    ch = $urandom_range(0, CHANNELS - 1);
                queue_sample(ch, pick_sample());
            end
            wait_drained();
        end

        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
